FILE: sv/edfs_pkg.sv
package edfs_pkg;

    localparam int MaxTasksDefault = 32;
    localparam int IdSpace = 32;
    localparam int IdW = 5;
    localparam int PeriodW = 31;
    localparam int DlW = 32;
    localparam int CountW = 6;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_TICK = 2'd1,
        ACT_DONE = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_IDLE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_TICK_RD,
        S_TICK_DIV,
        S_TICK_WR,
        S_REQ,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DISP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [DlW-1:0] dividend;
        logic [PeriodW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        zero_rem;
    } div_rsp_t;

endpackage

FILE: sv/edfs_ram.sv
module edfs_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/edfs_div.sv
module edfs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  edfs_pkg::div_req_t  req,
    output edfs_pkg::div_rsp_t  rsp
);

    localparam int DlW = edfs_pkg::DlW;

    logic [DlW-1:0] rem_reg, rem_next;
    logic [DlW-1:0] quo_reg, quo_next;
    logic [DlW-1:0] dvs_reg, dvs_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DlW:0]   trial;
    logic [DlW:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DlW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = {1'b0, req.divisor};
            cnt_next  = 6'(DlW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DlW-2:0], 1'b0};
            if (!trial[DlW])
            begin
                rem_next = trial[DlW-1:0];
            end
            else
            begin
                rem_next = shifted[DlW-1:0];
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.zero_rem = (rem_reg == '0);

endmodule

FILE: sv/edf_periodic_job_scheduler.sv
// one item at a time
// a tick checks each eligible task with the 32-step shared remainder unit, one task at a time
// rst_n clears used, pending, running state and tick count at once, no clearing pass
// task and deadline memories are undefined until written
module edf_periodic_job_scheduler #(
    parameter int MAX_TASKS = edfs_pkg::MaxTasksDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [edfs_pkg::IdW-1:0]     task_id,
    input  logic [edfs_pkg::PeriodW-1:0] period,
    input  logic [edfs_pkg::DlW-1:0]     first_deadline,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         running_valid,
    output logic [edfs_pkg::IdW-1:0]     running_task,
    output logic [edfs_pkg::DlW-1:0]     running_deadline,
    output logic [edfs_pkg::CountW-1:0]  ready_count,
    output logic [1:0]                   status
);

    localparam int IdW = edfs_pkg::IdW;
    localparam int PW = edfs_pkg::PeriodW;
    localparam int DlW = edfs_pkg::DlW;
    localparam int CW = edfs_pkg::CountW;
    localparam int N = (MAX_TASKS < edfs_pkg::IdSpace) ? MAX_TASKS : edfs_pkg::IdSpace;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam int IW = AW + 1;

    edfs_pkg::state_t state_reg, state_next;

    logic [N-1:0] used_reg, used_next;
    logic [N-1:0] pend_reg, pend_next;
    logic [DlW-1:0] tick_reg, tick_next;
    logic run_v_reg, run_v_next;
    logic [IdW-1:0] run_t_reg, run_t_next;
    logic [DlW-1:0] run_d_reg, run_d_next;
    logic [IdW-1:0] id_reg, id_next;
    logic [PW-1:0] per_reg, per_next;
    logic [DlW-1:0] first_reg, first_next;
    logic [1:0] st_reg, st_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic found_reg, found_next;
    logic [AW-1:0] best_reg, best_next;
    logic [DlW-1:0] bestd_reg, bestd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic ov_reg, ov_next;

    logic tp_we, td_we, jd_we;
    logic [AW-1:0] tp_wa, td_wa, jd_wa, tp_ra, td_ra, jd_ra;
    logic [PW-1:0] tp_wd, tp_rd;
    logic [DlW-1:0] td_wd, td_rd, jd_wd, jd_rd;

    edfs_pkg::div_req_t dreq;
    edfs_pkg::div_rsp_t drsp;

    edfs_ram #(.Width(PW), .Depth(N)) u_period (
        .clk(clk), .we(tp_we), .waddr(tp_wa), .wdata(tp_wd), .raddr(tp_ra), .rdata(tp_rd)
    );
    edfs_ram #(.Width(DlW), .Depth(N)) u_task_dl (
        .clk(clk), .we(td_we), .waddr(td_wa), .wdata(td_wd), .raddr(td_ra), .rdata(td_rd)
    );
    edfs_ram #(.Width(DlW), .Depth(N)) u_job_dl (
        .clk(clk), .we(jd_we), .waddr(jd_wa), .wdata(jd_wd), .raddr(jd_ra), .rdata(jd_rd)
    );
    edfs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [AW-1:0] idx_a;
    logic [AW-1:0] id_a;
    logic id_ok;
    logic idx_run;
    logic [DlW-1:0] sum_dl;

    assign idx_a = idx_reg[AW-1:0];
    assign id_a  = id_reg[AW-1:0];
    assign id_ok = ({{(32-IdW){1'b0}}, id_reg} < 32'(N));
    assign idx_run = run_v_reg && ({{(32-IdW){1'b0}}, run_t_reg} == 32'(idx_reg));
    assign sum_dl = td_rd + {1'b0, tp_rd};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edfs_pkg::S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    case (edfs_pkg::action_t'(action))
                        edfs_pkg::ACT_ADD:  state_next = edfs_pkg::S_ADD_RD;
                        edfs_pkg::ACT_TICK: state_next = edfs_pkg::S_TICK_RD;
                        edfs_pkg::ACT_DONE: state_next = edfs_pkg::S_SCAN_RD;
                        default:            state_next = edfs_pkg::S_OUT;
                    endcase
                end
            end
            edfs_pkg::S_ADD_RD:   state_next = id_ok ? edfs_pkg::S_ADD_WR : edfs_pkg::S_OUT;
            edfs_pkg::S_ADD_WR:   state_next = edfs_pkg::S_REQ;
            edfs_pkg::S_TICK_RD:
            begin
                if (idx_reg == IW'(N))
                begin
                    state_next = edfs_pkg::S_SCAN_RD;
                end
                else if (used_reg[idx_a] && !pend_reg[idx_a] && !idx_run)
                begin
                    state_next = edfs_pkg::S_TICK_DIV;
                end
            end
            edfs_pkg::S_TICK_DIV:
            begin
                if (tp_rd == '0)
                begin
                    state_next = edfs_pkg::S_TICK_RD;
                end
                else if (drsp.done)
                begin
                    state_next = drsp.zero_rem ? edfs_pkg::S_TICK_WR : edfs_pkg::S_TICK_RD;
                end
            end
            edfs_pkg::S_TICK_WR:  state_next = edfs_pkg::S_TICK_RD;
            edfs_pkg::S_REQ:      state_next = edfs_pkg::S_OUT;
            edfs_pkg::S_SCAN_RD:
            begin
                state_next = (idx_reg == IW'(N)) ? edfs_pkg::S_DISP : edfs_pkg::S_SCAN_CMP;
            end
            edfs_pkg::S_SCAN_CMP: state_next = edfs_pkg::S_SCAN_RD;
            edfs_pkg::S_DISP:     state_next = edfs_pkg::S_REQ;
            edfs_pkg::S_OUT:      state_next = edfs_pkg::S_IDLE;
            default:              state_next = edfs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        used_next  = used_reg;
        pend_next  = pend_reg;
        tick_next  = tick_reg;
        run_v_next = run_v_reg;
        run_t_next = run_t_reg;
        run_d_next = run_d_reg;
        id_next    = id_reg;
        per_next   = per_reg;
        first_next = first_reg;
        st_next    = st_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        tp_we = 1'b0; tp_wa = id_a; tp_wd = per_reg;
        td_we = 1'b0; td_wa = id_a; td_wd = first_reg;
        jd_we = 1'b0; jd_wa = id_a; jd_wd = first_reg;
        tp_ra = id_a; td_ra = id_a; jd_ra = idx_a;
        dreq.start    = 1'b0;
        dreq.dividend = tick_reg;
        dreq.divisor  = tp_rd;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            edfs_pkg::S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    id_next    = task_id;
                    per_next   = period;
                    first_next = first_deadline;
                    st_next    = edfs_pkg::ST_OK;
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (edfs_pkg::action_t'(action) == edfs_pkg::ACT_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    if (edfs_pkg::action_t'(action) == edfs_pkg::ACT_DONE)
                    begin
                        if (!run_v_reg)
                        begin
                            st_next = edfs_pkg::ST_IDLE;
                        end
                        run_v_next = 1'b0;
                    end
                end
            end
            edfs_pkg::S_ADD_RD:
            begin
                if (!id_ok)
                begin
                    st_next = edfs_pkg::ST_FULL;
                end
            end
            edfs_pkg::S_ADD_WR:
            begin
                if (!used_reg[id_a] || tp_rd != per_reg)
                begin
                    used_next[id_a] = 1'b1;
                    tp_we = 1'b1;
                    td_we = 1'b1;
                end
                if (!pend_reg[id_a] && !(run_v_reg && run_t_reg == id_reg))
                begin
                    pend_next[id_a] = 1'b1;
                    jd_we = 1'b1;
                end
            end
            edfs_pkg::S_TICK_RD:
            begin
                tp_ra = idx_a;
                td_ra = idx_a;
                if (idx_reg != IW'(N) && !(used_reg[idx_a] && !pend_reg[idx_a] && !idx_run))
                begin
                    idx_next = idx_reg + IW'(1);
                end
                if (idx_reg == IW'(N))
                begin
                    idx_next = '0;
                    if (run_v_reg && {{(32-IdW){1'b0}}, run_t_reg} < 32'(N))
                    begin
                        pend_next[run_t_reg[AW-1:0]] = 1'b1;
                        jd_we = 1'b1;
                        jd_wa = run_t_reg[AW-1:0];
                        jd_wd = run_d_reg;
                    end
                    run_v_next = 1'b0;
                end
            end
            edfs_pkg::S_TICK_DIV:
            begin
                tp_ra = idx_a;
                td_ra = idx_a;
                dreq.start = !drsp.busy && !drsp.done && tp_rd != '0;
                if (tp_rd == '0 || (drsp.done && !drsp.zero_rem))
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            edfs_pkg::S_TICK_WR:
            begin
                tp_ra = idx_a;
                td_ra = idx_a;
                if (tp_rd != '0)
                begin
                    td_we = 1'b1; td_wa = idx_a; td_wd = sum_dl;
                    jd_we = 1'b1; jd_wa = idx_a; jd_wd = sum_dl;
                    pend_next[idx_a] = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
            end
            edfs_pkg::S_SCAN_RD:
            begin
                if (idx_reg == IW'(N))
                begin
                    idx_next = '0;
                end
            end
            edfs_pkg::S_SCAN_CMP:
            begin
                if (pend_reg[idx_a] && (!found_reg || jd_rd < bestd_reg))
                begin
                    found_next = 1'b1;
                    best_next  = idx_a;
                    bestd_next = jd_rd;
                end
                idx_next = idx_reg + IW'(1);
                jd_ra = idx_next[AW-1:0];
            end
            edfs_pkg::S_DISP:
            begin
                run_v_next = found_reg;
                run_t_next = found_reg ? IdW'(best_reg) : '0;
                run_d_next = found_reg ? bestd_reg : '0;
                if (found_reg)
                begin
                    pend_next[best_reg] = 1'b0;
                end
            end
            edfs_pkg::S_REQ:
            begin
                cnt_next = CW'($countones(pend_reg));
            end
            edfs_pkg::S_OUT:
            begin
                ov_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edfs_pkg::S_IDLE;
            used_reg  <= '0;
            pend_reg  <= '0;
            tick_reg  <= '0;
            run_v_reg <= 1'b0;
            run_t_reg <= '0;
            run_d_reg <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            st_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            tick_reg  <= tick_next;
            run_v_reg <= run_v_next;
            run_t_reg <= run_t_next;
            run_d_reg <= run_d_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        per_reg   <= per_next;
        first_reg <= first_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
    end

    assign in_ready         = (state_reg == edfs_pkg::S_IDLE) && !ov_reg;
    assign out_valid        = ov_reg;
    assign running_valid    = run_v_reg;
    assign running_task     = run_v_reg ? run_t_reg : '0;
    assign running_deadline = run_v_reg ? run_d_reg : '0;
    assign ready_count      = cnt_reg;
    assign status           = st_reg;

endmodule

FILE: sv/edfs_checker.sv
module edfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       running_valid,
    input logic [4:0] running_task,
    input logic [5:0] ready_count,
    input logic [1:0] status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result waits");

    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> running_task == 5'd0)
        else $error("task shown with nothing running");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ready_count <= 6'd32 && status != 2'd3)
        else $error("result fields out of range");

endmodule

bind edf_periodic_job_scheduler edfs_checker u_edfs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .running_valid(running_valid),
    .running_task(running_task), .ready_count(ready_count), .status(status)
);

FILE: tb/sv/edf_periodic_job_scheduler_checker.sv
module edf_periodic_job_scheduler_checker
    import edfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [IdW-1:0]       task_id,
    input  logic [PeriodW-1:0]   period,
    input  logic [DlW-1:0]       first_deadline,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 running_valid,
    input  logic [IdW-1:0]       running_task,
    input  logic [DlW-1:0]       running_deadline,
    input  logic [CountW-1:0]    ready_count,
    input  logic [1:0]           status,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic              run_v;
        logic [IdW-1:0]    run_id;
        logic [DlW-1:0]    run_dl;
        logic [CountW-1:0] count;
        logic [1:0]        st;
    } sched_view_t;

    logic               used_q [IdSpace];
    logic [PeriodW-1:0] per_q [IdSpace];
    logic [DlW-1:0]     next_dl_q [IdSpace];
    logic               pend_q [IdSpace];
    logic [DlW-1:0]     job_dl_q [IdSpace];
    logic [DlW-1:0]     ticks;
    logic               cur_v;
    logic [IdW-1:0]     cur_id;
    logic [DlW-1:0]     cur_dl;
    sched_view_t        expected_views [$];

    function automatic void pick_earliest();
        bit found;
        int best;
        found = 0;
        best = 0;
        for (int i = 0; i < IdSpace; i++)
        begin
            if (pend_q[i] && (!found || job_dl_q[i] < job_dl_q[best]))
            begin
                best = i;
                found = 1;
            end
        end
        if (found)
        begin
            pend_q[best] = 0;
            cur_v = 1;
            cur_id = best[IdW-1:0];
            cur_dl = job_dl_q[best];
        end
        else
        begin
            cur_v = 0;
            cur_id = '0;
            cur_dl = '0;
        end
    endfunction

    function automatic sched_view_t schedule_step(action_t a, logic [IdW-1:0] id,
                                                  logic [PeriodW-1:0] p, logic [DlW-1:0] dl);
        sched_view_t v;
        int cnt;
        v = '0;
        v.st = ST_OK;
        case (a)
            ACT_ADD:
            begin
                if (!used_q[id] || per_q[id] != p)
                begin
                    used_q[id] = 1;
                    per_q[id] = p;
                    next_dl_q[id] = dl;
                end
                if (!pend_q[id] && !(cur_v && cur_id == id))
                begin
                    pend_q[id] = 1;
                    job_dl_q[id] = dl;
                end
            end
            ACT_TICK:
            begin
                ticks = ticks + 1;
                for (int i = 0; i < IdSpace; i++)
                begin
                    if (used_q[i] && per_q[i] != 0 && (ticks % {1'b0, per_q[i]}) == 0
                        && !pend_q[i] && !(cur_v && cur_id == i))
                    begin
                        next_dl_q[i] = next_dl_q[i] + {1'b0, per_q[i]};
                        pend_q[i] = 1;
                        job_dl_q[i] = next_dl_q[i];
                    end
                end
                if (cur_v)
                begin
                    pend_q[cur_id] = 1;
                    job_dl_q[cur_id] = cur_dl;
                end
                pick_earliest();
            end
            ACT_DONE:
            begin
                if (!cur_v)
                    v.st = ST_IDLE;
                pick_earliest();
            end
            default: ;
        endcase
        cnt = 0;
        for (int i = 0; i < IdSpace; i++)
            if (pend_q[i])
                cnt++;
        v.run_v = cur_v;
        v.run_id = cur_v ? cur_id : '0;
        v.run_dl = cur_v ? cur_dl : '0;
        v.count = cnt[CountW-1:0];
        return v;
    endfunction

    assign outstanding = expected_views.size();

    always @(posedge clk or negedge rst_n)
    begin
        sched_view_t got;
        sched_view_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < IdSpace; i++)
            begin
                used_q[i] = 0;
                pend_q[i] = 0;
                per_q[i] = '0;
                next_dl_q[i] = '0;
                job_dl_q[i] = '0;
            end
            ticks = '0;
            cur_v = 0;
            cur_id = '0;
            cur_dl = '0;
            expected_views.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {running_valid, running_task, running_deadline, ready_count, status};
                if (expected_views.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_views.push_back(schedule_step(action_t'(action), task_id,
                                                       period, first_deadline));
        end
    end

endmodule

FILE: tb/sv/edf_periodic_job_scheduler_tb.sv
module edf_periodic_job_scheduler_tb;
    import edfs_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [IdW-1:0]     task_id;
    logic [PeriodW-1:0] period;
    logic [DlW-1:0]     first_deadline;
    logic               out_valid;
    logic               out_ready;
    logic               running_valid;
    logic [IdW-1:0]     running_task;
    logic [DlW-1:0]     running_deadline;
    logic [CountW-1:0]  ready_count;
    logic [1:0]         status;
    int                 fail_count;
    int                 outstanding;
    bit                 quiet;

    edf_periodic_job_scheduler u_top (.*);

    edf_periodic_job_scheduler_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * 4000000);
        $display("edf_periodic_job_scheduler_tb: FAIL");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic send_job_cmd(action_t a, int id, logic [PeriodW-1:0] p,
                                logic [DlW-1:0] dl);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1;
        action <= a;
        task_id <= id[IdW-1:0];
        period <= p;
        first_deadline <= dl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_cmd();
        int r;
        logic [DlW-1:0] dl;
        r = $urandom_range(0, 99);
        dl = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 40);
        if (r < 35)
            send_job_cmd(ACT_ADD, $urandom_range(0, 31),
                         PeriodW'(($urandom_range(0, 5) == 0) ? $urandom()
                                                              : $urandom_range(0, 8)), dl);
        else if (r < 75)
            send_job_cmd(ACT_TICK, $urandom_range(0, 31), PeriodW'($urandom()), $urandom());
        else if (r < 95)
            send_job_cmd(ACT_DONE, $urandom_range(0, 31), PeriodW'($urandom()), $urandom());
        else
            send_job_cmd(ACT_NONE, $urandom_range(0, 31), PeriodW'($urandom()), $urandom());
    endtask

    initial
    begin
        int guard;
        quiet = 0;
        rst_n = 0;
        in_valid = 0;
        action = ACT_NONE;
        task_id = '0;
        period = '0;
        first_deadline = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_TICK, 0, '0, '0);
        send_job_cmd(ACT_ADD, 0, 31'd1, 32'd0);
        send_job_cmd(ACT_ADD, 31, 31'h7fffffff, 32'hffffffff);
        send_job_cmd(ACT_ADD, 5, 31'd0, 32'd7);
        send_job_cmd(ACT_ADD, 6, 31'd2, 32'd7);
        send_job_cmd(ACT_ADD, 6, 31'd2, 32'd3);
        send_job_cmd(ACT_ADD, 7, 31'd3, 32'hfffffffe);
        send_job_cmd(ACT_TICK, 0, '0, '0);
        send_job_cmd(ACT_ADD, 0, 31'd1, 32'd9);
        send_job_cmd(ACT_ADD, 6, 31'd4, 32'd1);
        send_job_cmd(ACT_NONE, 31, 31'h7fffffff, 32'hffffffff);
        send_job_cmd(ACT_TICK, 0, '0, '0);
        send_job_cmd(ACT_TICK, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_TICK, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        send_job_cmd(ACT_DONE, 0, '0, '0);
        in_valid <= 0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);

        for (int n = 0; n < 290; n++)
        begin
            if (n == 240)
                quiet = 1;
            send_random_cmd();
        end
        in_valid <= 0;

        @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (3000) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("edf_periodic_job_scheduler_tb: PASS");
        else
            $display("edf_periodic_job_scheduler_tb: FAIL");
        $finish;
    end

endmodule
